/* rtl/scld_pkg.sv */
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types and constants of the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  // Line store geometry
  localparam int unsigned LineMax   = 15;
  localparam int unsigned PosW      = $clog2(LineMax + 1);
  localparam int unsigned PrefixLen = 4;

  // Command texts, one row per command, checked in this order of priority
  localparam int unsigned NumCmd  = 7;
  localparam int unsigned IdxRpm  = 0;
  localparam int unsigned IdxSpd  = 1;
  localparam int unsigned IdxErr  = 2;
  localparam int unsigned IdxRbw  = 3;
  localparam int unsigned IdxClr  = 4;
  localparam int unsigned IdxBrt  = 5;
  localparam int unsigned IdxVib  = 6;

  localparam logic [7:0] CmdText [NumCmd][PrefixLen] = '{
    '{"R", "P", "M", ":"},
    '{"S", "P", "D", ":"},
    '{"E", 8'h00, 8'h00, 8'h00},
    '{"R", 8'h00, 8'h00, 8'h00},
    '{"C", "L", "R", 8'h00},
    '{"B", "R", "T", ":"},
    '{"V", "I", "B", ":"}
  };
  localparam logic [2:0] CmdLen [NumCmd] = '{3'd4, 3'd4, 3'd1, 3'd1, 3'd3, 3'd4, 3'd4};
  localparam logic [7:0] LedText [PrefixLen] = '{"L", "E", "D", ":"};

  // Character codes
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharMax   = 8'd126;
  localparam logic [7:0] CharPlus  = "+";
  localparam logic [7:0] CharMinus = "-";
  localparam logic [7:0] CharZero  = "0";
  localparam logic [7:0] CharNine  = "9";

  // Register reset values
  localparam logic [15:0] TimeoutRst = 16'd5000;
  localparam logic [15:0] StartupRst = 16'd3000;
  localparam logic [7:0]  HapticRst  = 8'd51;
  localparam logic [7:0]  BrightRst  = 8'd255;

  localparam int unsigned OutDataW = 56;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_RPM     = 4'd1,
    CMD_SPD     = 4'd2,
    CMD_ERR     = 4'd3,
    CMD_RAINBOW = 4'd4,
    CMD_CLR     = 4'd5,
    CMD_BRT     = 4'd6,
    CMD_VIB     = 4'd7,
    CMD_UNKNOWN = 4'd8
  } cmd_kind_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_STARTUP = 2'd1,
    CFG_HAPTIC  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    NUM_SPACE,
    NUM_DIGIT,
    NUM_DONE
  } num_state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } parse_ctl_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] value;
  } parse_res_t;

endpackage

/* rtl/scld_parser.sv */
// ----------------------------------------------------------------------------
// scld_parser
// Character-serial command matcher and decimal number accumulator.
// ----------------------------------------------------------------------------
module scld_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scld_pkg::parse_ctl_t ctl_i,
  input  logic [7:0]           char_i,
  output scld_pkg::parse_res_t res_o
);

  logic [2:0]                      apos_q, apos_d;
  logic                            led_q, led_d;
  logic [scld_pkg::PosW-1:0]       cpos_q, cpos_d;
  logic [scld_pkg::NumCmd-1:0]     alive_q, alive_d;
  scld_pkg::num_state_e            nst_q, nst_d;
  logic                            neg_q, neg_d;
  logic [15:0]                     num_q, num_d;

  logic                            is_digit;
  logic [3:0]                      digit;
  logic [15:0]                     num_x10;
  logic                            cmd_zone;

  assign is_digit = (char_i >= scld_pkg::CharZero) && (char_i <= scld_pkg::CharNine);
  assign digit    = 4'(char_i - scld_pkg::CharZero);
  // v*10 + d as two shifts and two adds, wrapping at 16 bits
  assign num_x10  = {num_q[12:0], 3'b000} + {num_q[14:0], 1'b0} + {12'd0, digit};
  assign cmd_zone = cpos_q < scld_pkg::PosW'(scld_pkg::PrefixLen);

  always_comb begin
    apos_d  = apos_q;
    led_d   = led_q;
    cpos_d  = cpos_q;
    alive_d = alive_q;
    nst_d   = nst_q;
    neg_d   = neg_q;
    num_d   = num_q;
    if (ctl_i.clear) begin
      apos_d  = '0;
      led_d   = 1'b1;
      cpos_d  = '0;
      alive_d = '1;
      nst_d   = scld_pkg::NUM_SPACE;
      neg_d   = 1'b0;
      num_d   = '0;
    end else if (ctl_i.step) begin
      cpos_d = cpos_q + 1'b1;
      if (cmd_zone) begin
        for (int i = 0; i < scld_pkg::NumCmd; i++) begin
          if (cpos_q < scld_pkg::PosW'(scld_pkg::CmdLen[i])) begin
            alive_d[i] = alive_q[i] && (char_i == scld_pkg::CmdText[i][cpos_q[1:0]]);
          end
        end
      end else begin
        case (nst_q)
          scld_pkg::NUM_SPACE: begin
            if (char_i == scld_pkg::CharSpace) begin
              nst_d = scld_pkg::NUM_SPACE;
            end else if (char_i == scld_pkg::CharPlus || char_i == scld_pkg::CharMinus) begin
              neg_d = (char_i == scld_pkg::CharMinus);
              nst_d = scld_pkg::NUM_DIGIT;
            end else if (is_digit) begin
              num_d = {12'd0, digit};
              nst_d = scld_pkg::NUM_DIGIT;
            end else begin
              nst_d = scld_pkg::NUM_DONE;
            end
          end
          scld_pkg::NUM_DIGIT: begin
            if (is_digit) begin
              num_d = num_x10;
            end else begin
              nst_d = scld_pkg::NUM_DONE;
            end
          end
          default: nst_d = scld_pkg::NUM_DONE;
        endcase
      end
      // "LED:" prefix: on its fourth char restart the command match and the number
      if (apos_q != 3'(scld_pkg::PrefixLen)) begin
        apos_d = apos_q + 1'b1;
        led_d  = led_q && (char_i == scld_pkg::LedText[apos_q[1:0]]);
        if (apos_q == 3'(scld_pkg::PrefixLen - 1) && led_d) begin
          cpos_d  = '0;
          alive_d = '1;
          nst_d   = scld_pkg::NUM_SPACE;
          neg_d   = 1'b0;
          num_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apos_q  <= '0;
      led_q   <= 1'b1;
      cpos_q  <= '0;
      alive_q <= '1;
      nst_q   <= scld_pkg::NUM_SPACE;
      neg_q   <= 1'b0;
      num_q   <= '0;
    end else begin
      apos_q  <= apos_d;
      led_q   <= led_d;
      cpos_q  <= cpos_d;
      alive_q <= alive_d;
      nst_q   <= nst_d;
      neg_q   <= neg_d;
      num_q   <= num_d;
    end
  end

  // cpos_q is the line length after any "LED:" prefix once the whole line has been stepped
  function automatic logic pfx_ok(input logic alive, input logic [scld_pkg::PosW-1:0] len);
    return alive && (len >= scld_pkg::PosW'(scld_pkg::PrefixLen));
  endfunction

  always_comb begin
    res_o.value = neg_q ? 16'(16'd0 - num_q) : num_q;
    if (pfx_ok(alive_q[scld_pkg::IdxRpm], cpos_q)) begin
      res_o.kind = scld_pkg::CMD_RPM;
    end else if (pfx_ok(alive_q[scld_pkg::IdxSpd], cpos_q)) begin
      res_o.kind = scld_pkg::CMD_SPD;
    end else if (alive_q[scld_pkg::IdxErr] &&
                 cpos_q == scld_pkg::PosW'(scld_pkg::CmdLen[scld_pkg::IdxErr])) begin
      res_o.kind = scld_pkg::CMD_ERR;
    end else if (alive_q[scld_pkg::IdxRbw] &&
                 cpos_q == scld_pkg::PosW'(scld_pkg::CmdLen[scld_pkg::IdxRbw])) begin
      res_o.kind = scld_pkg::CMD_RAINBOW;
    end else if (alive_q[scld_pkg::IdxClr] &&
                 cpos_q == scld_pkg::PosW'(scld_pkg::CmdLen[scld_pkg::IdxClr])) begin
      res_o.kind = scld_pkg::CMD_CLR;
    end else if (pfx_ok(alive_q[scld_pkg::IdxBrt], cpos_q)) begin
      res_o.kind = scld_pkg::CMD_BRT;
    end else if (pfx_ok(alive_q[scld_pkg::IdxVib], cpos_q)) begin
      res_o.kind = scld_pkg::CMD_VIB;
    end else begin
      res_o.kind = scld_pkg::CMD_UNKNOWN;
    end
  end

endmodule

/* rtl/serial_command_line_decoder.sv */
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Collects serial bytes into a command line, decodes it and keeps the display
// and haptic settings; millisecond ticks drive timeout and pulse timers.
// ----------------------------------------------------------------------------
// Each input item is a received byte (tuser = 0) or a one millisecond tick
// (tuser = 1) and gives exactly one result item carrying the held settings.
// One item is handled at a time: a tick or a byte that ends no line is first
// updated, then loaded into the output register; a CR or LF that closes a
// line of stored characters passes through prime, scan, apply and emit, since
// the line store is read one character per cycle through its registered read
// port and fed to a single character-serial matcher and shift-add number
// accumulator. Input is not taken again until the result is in the output
// register, so a stalled output holds the block after one item.
// Configuration: index 0 timeout ticks, 1 start-up wait ticks, 2 haptic level;
// other indexes are ignored. Write only while idle.
module serial_command_line_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] req_type
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] rpm_value, [31:16] speed_value,
                                      // [32] error_mode, [33] rainbow_mode,
                                      // [41:34] brightness, [49:42] haptic_drive,
                                      // [50] timed_out, [55:51] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] cmd_kind
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PosW = scld_pkg::PosW;

  scld_pkg::seq_state_e state_q, state_d;

  // config registers
  logic [15:0] timeout_q, startup_q;
  logic [7:0]  hlevel_q;

  // line store
  logic [7:0]      line_mem [scld_pkg::LineMax + 1];
  logic [PosW-1:0] line_len_q, line_len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] rd_addr;
  logic [7:0]      rd_data_q;
  logic            mem_we;

  // held settings
  logic [15:0] rpm_q, rpm_d, speed_q, speed_d;
  logic        err_q, err_d, rb_q, rb_d;
  logic [7:0]  bright_q, bright_d;
  logic        hap_on_q, hap_on_d;
  logic [15:0] hap_left_q, hap_left_d;
  logic [15:0] idle_q, idle_d, up_q, up_d;
  scld_pkg::cmd_kind_e kind_q, kind_d;
  logic        fired_q, fired_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [scld_pkg::OutDataW-1:0]   out_data_q, out_data_d;
  logic [3:0]                      out_user_q, out_user_d;

  scld_pkg::parse_ctl_t pctl;
  scld_pkg::parse_res_t pres;

  logic        accept, is_tick, is_term, is_print, out_free, last_char;
  logic [15:0] idle_inc, up_inc;

  assign s_axis_tready = (state_q == scld_pkg::ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_tick   = (s_axis_tuser == scld_pkg::REQ_TICK);
  assign is_term   = (s_axis_tdata == scld_pkg::CharLf) || (s_axis_tdata == scld_pkg::CharCr);
  assign is_print  = s_axis_tdata inside {[scld_pkg::CharSpace:scld_pkg::CharMax]};
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_char = (pos_q == PosW'(line_len_q - 1'b1));
  assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign up_inc    = (up_q == 16'hFFFF) ? up_q : up_q + 16'd1;

  scld_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .char_i (rd_data_q),
    .res_o  (pres)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scld_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_tick && is_term && line_len_q != '0) state_d = scld_pkg::ST_PRIME;
          else                                         state_d = scld_pkg::ST_EMIT;
        end
      end
      scld_pkg::ST_PRIME: state_d = scld_pkg::ST_SCAN;
      scld_pkg::ST_SCAN:  if (last_char) state_d = scld_pkg::ST_APPLY;
      scld_pkg::ST_APPLY: state_d = scld_pkg::ST_EMIT;
      scld_pkg::ST_EMIT:  if (out_free) state_d = scld_pkg::ST_IDLE;
      default:            state_d = scld_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    line_len_d  = line_len_q;
    pos_d       = pos_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    rpm_d       = rpm_q;
    speed_d     = speed_q;
    err_d       = err_q;
    rb_d        = rb_q;
    bright_d    = bright_q;
    hap_on_d    = hap_on_q;
    hap_left_d  = hap_left_q;
    idle_d      = idle_q;
    up_d        = up_q;
    kind_d      = kind_q;
    fired_d     = fired_q;
    pctl        = '0;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      scld_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d  = scld_pkg::CMD_NONE;
          fired_d = 1'b0;
          if (!is_tick) begin
            idle_d = '0;
            if (!is_term && is_print && line_len_q < PosW'(scld_pkg::LineMax)) begin
              mem_we     = 1'b1;
              line_len_d = line_len_q + 1'b1;
            end
          end else begin
            up_d   = up_inc;
            idle_d = idle_inc;
            if (!err_q && idle_inc > timeout_q && up_inc > startup_q) begin
              err_d   = 1'b1;
              rb_d    = 1'b0;
              fired_d = 1'b1;
            end
            if (hap_on_q) begin
              if (hap_left_q != '0) hap_left_d = hap_left_q - 16'd1;
              if (hap_left_q <= 16'd1) hap_on_d = 1'b0;
            end
          end
        end
      end
      scld_pkg::ST_PRIME: begin
        pctl.clear = 1'b1;
        pos_d      = '0;
        rd_addr    = '0;
      end
      scld_pkg::ST_SCAN: begin
        pctl.step = 1'b1;
        pos_d     = pos_q + 1'b1;
        rd_addr   = pos_q + 1'b1;
      end
      scld_pkg::ST_APPLY: begin
        kind_d     = pres.kind;
        line_len_d = '0;
        case (pres.kind)
          scld_pkg::CMD_RPM: begin
            rpm_d = pres.value;
            err_d = 1'b0;
            rb_d  = 1'b0;
          end
          scld_pkg::CMD_SPD: speed_d = pres.value;
          scld_pkg::CMD_ERR: begin
            err_d = 1'b1;
            rb_d  = 1'b0;
          end
          scld_pkg::CMD_RAINBOW: begin
            err_d = 1'b1;
            rb_d  = 1'b1;
          end
          scld_pkg::CMD_CLR: begin
            rpm_d   = '0;
            speed_d = '0;
            err_d   = 1'b0;
            rb_d    = 1'b0;
          end
          scld_pkg::CMD_BRT: bright_d = pres.value[7:0];
          scld_pkg::CMD_VIB: begin
            hap_left_d = pres.value;
            hap_on_d   = (pres.value != '0);
          end
          default: ;
        endcase
      end
      scld_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, fired_q, (hap_on_q ? hlevel_q : 8'd0), bright_q,
                         rb_q, err_q, speed_q, rpm_q};
          out_user_d  = kind_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scld_pkg::ST_IDLE;
      line_len_q  <= '0;
      pos_q       <= '0;
      rpm_q       <= '0;
      speed_q     <= '0;
      err_q       <= 1'b0;
      rb_q        <= 1'b0;
      bright_q    <= scld_pkg::BrightRst;
      hap_on_q    <= 1'b0;
      hap_left_q  <= '0;
      idle_q      <= '0;
      up_q        <= '0;
      kind_q      <= scld_pkg::CMD_NONE;
      fired_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_len_q  <= line_len_d;
      pos_q       <= pos_d;
      rpm_q       <= rpm_d;
      speed_q     <= speed_d;
      err_q       <= err_d;
      rb_q        <= rb_d;
      bright_q    <= bright_d;
      hap_on_q    <= hap_on_d;
      hap_left_q  <= hap_left_d;
      idle_q      <= idle_d;
      up_q        <= up_d;
      kind_q      <= kind_d;
      fired_q     <= fired_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // line store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[line_len_q] <= s_axis_tdata;
    rd_data_q <= line_mem[rd_addr];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= scld_pkg::TimeoutRst;
      startup_q <= scld_pkg::StartupRst;
      hlevel_q  <= scld_pkg::HapticRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scld_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        scld_pkg::CFG_STARTUP: startup_q <= cfg_data_i;
        scld_pkg::CFG_HAPTIC:  hlevel_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // scan only runs over a non-empty line
  a_scan_has_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scld_pkg::ST_SCAN) |-> (line_len_q != '0))
    else $error("line scan with empty line store");

  // a running pulse always has ticks left
  a_pulse_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hap_on_q |-> (hap_left_q != '0))
    else $error("haptic pulse active with zero ticks left");

  // rainbow is a variant of error mode
  a_rainbow_in_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rb_q |-> err_q)
    else $error("rainbow mode without error mode");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != scld_pkg::ST_IDLE))
    else $error("sequencer stayed idle after accepting an item");

endmodule
